FILE: rtl/tcc_pkg.sv
// shared types and constants of the text console cursor engine
package tcc_pkg;

    // command codes of an input word
    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_SET   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    // action codes of a result word
    localparam logic [2:0] ACT_GLYPH      = 3'd0;
    localparam logic [2:0] ACT_CLEAR      = 3'd1;
    localparam logic [2:0] ACT_SCROLL     = 3'd2;
    localparam logic [2:0] ACT_FILL       = 3'd3;
    localparam logic [2:0] ACT_CURSOR_ON  = 3'd4;
    localparam logic [2:0] ACT_CURSOR_OFF = 3'd5;

    // control characters
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_DELETE    = 8'h7F;
    localparam logic [7:0] CH_TAB       = 8'h09;

    // tab stops every eight columns
    localparam logic [8:0] TAB_STEP = 9'd8;
    localparam logic [8:0] TAB_MASK = 9'h1F8;

    // configuration registers
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ROWS = 2'd1;
    localparam logic [7:0] COLUMNS_RESET   = 8'd80;
    localparam logic [7:0] TEXT_ROWS_RESET = 8'd25;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_CELLS = 3'b010,
        ST_TAIL  = 3'b100
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;       // take the input word and plan it
        logic emit_cell;  // send the current cell word
        logic emit_tail;  // send the closing word
        logic last;       // word being sent closes the input
    } t_ctl_cmd;

    // datapath to controller
    typedef struct packed {
        logic plan_cells; // planned word has cell actions
        logic plan_tail;  // planned word has a closing action
        logic cell_final; // current cell is the last of the run
        logic run_tail;   // closing action pending for this word
        logic out_free;   // output register can take a word
    } t_ctl_sts;

endpackage

FILE: rtl/tcc_if.sv
// handshake channels of the text console cursor engine

interface tcc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] char_code;
    logic [7:0] new_col;
    logic [7:0] new_row;

    modport source (output valid, command, char_code, new_col, new_row, input ready);
    modport sink   (input valid, command, char_code, new_col, new_row, output ready);
endinterface

interface tcc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] cell_col;
    logic [7:0] cell_row;
    logic [7:0] glyph;
    logic       last;
    logic [7:0] cursor_col;
    logic [7:0] cursor_row;

    modport source (output valid, action, cell_col, cell_row, glyph, last,
                    cursor_col, cursor_row, input ready);
    modport sink   (input valid, action, cell_col, cell_row, glyph, last,
                    cursor_col, cursor_row, output ready);
endinterface

interface tcc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [tcc_pkg::CFG_IDX_W-1:0] index;
    logic [7:0]                    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/text_console_cursor_engine.sv
// top level of the text console cursor engine
// usage:
//   i_in  takes one command word: put character, set cursor or clear screen
//   o_out gives the drawing words for it in cell units, one word per cycle at
//         most, last set on the final word; every word of a command carries
//         the cursor position that the command leaves
//   i_cfg writes columns (index 0) and text_rows (index 1); always ready; the
//         user must write only while the engine is idle, which it does not enforce
// timing:
//   a command is planned at once when it is taken; its words then leave
//   one per cycle through the output register while o_out is ready, up to nine
//   for a tab that scrolls (a newline without scroll and the unused command
//   leave no words); the next command is taken once the controller is back
//   in idle, while the last word may still wait in the output register
// reset: columns 80, text_rows 25, cursor at column 0 row 0, no word pending
// stall: a low ready on o_out holds the output word and pauses the sequencer
module text_console_cursor_engine (
    input  logic     i_clk,
    input  logic     i_rst_n,
    tcc_in_if.sink   i_in,
    tcc_out_if.source o_out,
    tcc_cfg_if.sink  i_cfg
);

    tcc_pkg::t_ctl_cmd ctl_cmd;
    tcc_pkg::t_ctl_sts ctl_sts;
    logic              in_ready;

    // configuration is taken every cycle
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = in_ready;

    // sequencer: idle, cell run, closing word
    tcc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (ctl_sts),
        .o_cmd      (ctl_cmd)
    );

    // cursor, plan and output word
    tcc_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg.valid),
        .i_cfg_index  (i_cfg.index),
        .i_cfg_data   (i_cfg.data),
        .i_command    (i_in.command),
        .i_char_code  (i_in.char_code),
        .i_new_col    (i_in.new_col),
        .i_new_row    (i_in.new_row),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_action     (o_out.action),
        .o_cell_col   (o_out.cell_col),
        .o_cell_row   (o_out.cell_row),
        .o_glyph      (o_out.glyph),
        .o_last       (o_out.last),
        .o_cursor_col (o_out.cursor_col),
        .o_cursor_row (o_out.cursor_row),
        .i_cmd        (ctl_cmd),
        .o_sts        (ctl_sts)
    );

endmodule

FILE: rtl/tcc_ctrl.sv
// controller state machine of the text console cursor engine
module tcc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tcc_pkg::t_ctl_sts i_sts,
    output tcc_pkg::t_ctl_cmd o_cmd
);

    tcc_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            tcc_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    priority if (i_sts.plan_cells) begin
                        n_state = tcc_pkg::ST_CELLS;
                    end else if (i_sts.plan_tail) begin
                        n_state = tcc_pkg::ST_TAIL;
                    end else begin
                        n_state = tcc_pkg::ST_IDLE;
                    end
                end
            end
            tcc_pkg::ST_CELLS: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_cell = 1'b1;
                    o_cmd.last      = i_sts.cell_final && !i_sts.run_tail;
                    if (i_sts.cell_final) begin
                        n_state = i_sts.run_tail ? tcc_pkg::ST_TAIL : tcc_pkg::ST_IDLE;
                    end
                end
            end
            tcc_pkg::ST_TAIL: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_tail = 1'b1;
                    o_cmd.last      = 1'b1;
                    n_state         = tcc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tcc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/tcc_datapath.sv
// cursor state, command planning and output register of the cursor engine
module tcc_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write
    input  logic                          i_cfg_we,
    input  logic [tcc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                    i_cfg_data,
    // input word
    input  logic [1:0]                    i_command,
    input  logic [7:0]                    i_char_code,
    input  logic [7:0]                    i_new_col,
    input  logic [7:0]                    i_new_row,
    // output word
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [2:0]                    o_action,
    output logic [7:0]                    o_cell_col,
    output logic [7:0]                    o_cell_row,
    output logic [7:0]                    o_glyph,
    output logic                          o_last,
    output logic [7:0]                    o_cursor_col,
    output logic [7:0]                    o_cursor_row,
    // controller
    input  tcc_pkg::t_ctl_cmd             i_cmd,
    output tcc_pkg::t_ctl_sts             o_sts
);

    // configuration and cursor
    logic [7:0] r_columns, r_text_rows;
    logic [7:0] r_cur_col, r_cur_row;

    // run of cell actions and closing action
    logic [7:0] r_x, r_y, r_glyph;
    logic [2:0] r_act;
    logic [3:0] r_cnt;
    logic       r_tail;
    logic [2:0] r_tail_act;
    logic       r_tail_cursor;

    // output register
    logic       r_out_valid;
    logic [2:0] r_o_act;
    logic [7:0] r_o_col, r_o_row, r_o_glyph, r_o_cur_col, r_o_cur_row;
    logic       r_o_last;

    // plan of the presented input word
    logic [7:0] p_x, p_y, p_glyph;
    logic [2:0] p_act;
    logic [3:0] p_cnt;
    logic       p_tail;
    logic [2:0] p_tail_act;
    logic       p_tail_cursor;
    logic [7:0] p_fin_col, p_fin_row;
    logic       p_move;

    // character step working values, nine bits so that 255 + 1 does not wrap
    logic [8:0] x1, y1, stop;

    always_comb begin
        p_x           = r_cur_col;
        p_y           = r_cur_row;
        p_glyph       = 8'd0;
        p_act         = tcc_pkg::ACT_CLEAR;
        p_cnt         = 4'd0;
        p_tail        = 1'b0;
        p_tail_act    = tcc_pkg::ACT_SCROLL;
        p_tail_cursor = 1'b0;
        p_fin_col     = r_cur_col;
        p_fin_row     = r_cur_row;
        p_move        = 1'b0;
        x1            = {1'b0, r_cur_col};
        y1            = {1'b0, r_cur_row};
        stop          = 9'd0;
        unique case (i_command)
            tcc_pkg::CMD_PUT: begin
                p_move = 1'b1;
                priority if (i_char_code == tcc_pkg::CH_NEWLINE) begin
                    x1 = 9'd0;
                    y1 = {1'b0, r_cur_row} + 9'd1;
                end else if (i_char_code == tcc_pkg::CH_BACKSPACE) begin
                    // step back, across a line start when there is a row above
                    if (r_cur_col != 8'd0) begin
                        p_x = r_cur_col - 8'd1;
                    end else if (r_cur_row != 8'd0) begin
                        p_y = r_cur_row - 8'd1;
                        p_x = r_columns - 8'd1;
                    end
                    p_cnt = 4'd1;
                    x1    = {1'b0, p_x};
                    y1    = {1'b0, p_y};
                end else if (i_char_code == tcc_pkg::CH_DELETE) begin
                    p_cnt = 4'd1;
                end else if (i_char_code == tcc_pkg::CH_TAB) begin
                    stop = ({1'b0, r_cur_col} + tcc_pkg::TAB_STEP) & tcc_pkg::TAB_MASK;
                    if (stop >= {1'b0, r_columns}) begin
                        stop = {1'b0, r_columns};
                    end
                    if ({1'b0, r_cur_col} < stop) begin
                        p_cnt = 4'(stop - {1'b0, r_cur_col});
                        x1    = stop;
                    end
                end else begin
                    p_act   = tcc_pkg::ACT_GLYPH;
                    p_glyph = i_char_code;
                    p_cnt   = 4'd1;
                    x1      = {1'b0, r_cur_col} + 9'd1;
                end
                // wrap the line, then scroll
                if (x1 >= {1'b0, r_columns}) begin
                    x1 = 9'd0;
                    y1 = y1 + 9'd1;
                end
                if (y1 >= {1'b0, r_text_rows}) begin
                    p_tail = 1'b1;
                    y1     = {1'b0, r_text_rows - 8'd1};
                end
                p_fin_col = x1[7:0];
                p_fin_row = y1[7:0];
            end
            tcc_pkg::CMD_SET: begin
                p_move        = 1'b1;
                p_act         = tcc_pkg::ACT_CURSOR_OFF;
                p_cnt         = 4'd1;
                p_tail        = 1'b1;
                p_tail_act    = tcc_pkg::ACT_CURSOR_ON;
                p_tail_cursor = 1'b1;
                p_fin_col     = i_new_col;
                p_fin_row     = i_new_row;
            end
            tcc_pkg::CMD_CLEAR: begin
                p_move     = 1'b1;
                p_tail     = 1'b1;
                p_tail_act = tcc_pkg::ACT_FILL;
                p_fin_col  = 8'd0;
                p_fin_row  = 8'd0;
            end
            tcc_pkg::CMD_NONE: begin
                p_move = 1'b0;
            end
            default: begin
                p_move = 1'b0;
            end
        endcase
    end

    // configuration and cursor registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns   <= tcc_pkg::COLUMNS_RESET;
            r_text_rows <= tcc_pkg::TEXT_ROWS_RESET;
            r_cur_col   <= 8'd0;
            r_cur_row   <= 8'd0;
        end else begin
            if (i_cfg_we && i_cfg_index == tcc_pkg::CFG_COLUMNS) begin
                r_columns <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == tcc_pkg::CFG_TEXT_ROWS) begin
                r_text_rows <= i_cfg_data;
            end
            if (i_cmd.load && p_move) begin
                r_cur_col <= p_fin_col;
                r_cur_row <= p_fin_row;
            end
        end
    end

    // run registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 4'd0;
            r_tail <= 1'b0;
        end else if (i_cmd.load) begin
            r_cnt  <= p_cnt;
            r_tail <= p_tail;
        end else if (i_cmd.emit_cell) begin
            r_cnt <= r_cnt - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x           <= p_x;
            r_y           <= p_y;
            r_glyph       <= p_glyph;
            r_act         <= p_act;
            r_tail_act    <= p_tail_act;
            r_tail_cursor <= p_tail_cursor;
        end else if (i_cmd.emit_cell) begin
            r_x <= r_x + 8'd1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_cell || i_cmd.emit_tail) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_cell) begin
            r_o_act   <= r_act;
            r_o_col   <= r_x;
            r_o_row   <= r_y;
            r_o_glyph <= r_glyph;
        end else if (i_cmd.emit_tail) begin
            r_o_act   <= r_tail_act;
            r_o_col   <= r_tail_cursor ? r_cur_col : 8'd0;
            r_o_row   <= r_tail_cursor ? r_cur_row : 8'd0;
            r_o_glyph <= 8'd0;
        end
        if (i_cmd.emit_cell || i_cmd.emit_tail) begin
            r_o_last    <= i_cmd.last;
            r_o_cur_col <= r_cur_col;
            r_o_cur_row <= r_cur_row;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_action     = r_o_act;
    assign o_cell_col   = r_o_col;
    assign o_cell_row   = r_o_row;
    assign o_glyph      = r_o_glyph;
    assign o_last       = r_o_last;
    assign o_cursor_col = r_o_cur_col;
    assign o_cursor_row = r_o_cur_row;

    assign o_sts.plan_cells = (p_cnt != 4'd0);
    assign o_sts.plan_tail  = p_tail;
    assign o_sts.cell_final = (r_cnt == 4'd1);
    assign o_sts.run_tail   = r_tail;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

endmodule

FILE: sim/text_console_cursor_engine_checker.sv
// scoreboard that predicts and checks the drawing words of the text console cursor engine
module text_console_cursor_engine_checker
    import tcc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    tcc_in_if    i_in,
    tcc_out_if   i_out,
    tcc_cfg_if   i_cfg,
    output int   o_mismatches,
    output int   o_draws_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    typedef struct {
        logic [2:0] action;
        logic [7:0] cell_col;
        logic [7:0] cell_row;
        logic [7:0] glyph;
        logic       last;
        logic [7:0] cursor_col;
        logic [7:0] cursor_row;
    } t_draw;

    // screen size and cursor as the engine should hold them
    logic [7:0] screen_cols;
    logic [7:0] screen_rows;
    logic [7:0] cursor_col;
    logic [7:0] cursor_row;

    t_draw queued_draws[$];
    int    mismatches = 0;

    function automatic t_draw cell_draw(logic [2:0] act, int unsigned col, int unsigned row,
                                        logic [7:0] g);
        t_draw d;
        d.action     = act;
        d.cell_col   = col[7:0];
        d.cell_row   = row[7:0];
        d.glyph      = g;
        d.last       = 1'b0;
        d.cursor_col = '0;
        d.cursor_row = '0;
        return d;
    endfunction

    // drawing words for one command word, cursor moved as a side effect
    function automatic void plan_drawing(logic [1:0] cmd, logic [7:0] ch, logic [7:0] set_col,
                                         logic [7:0] set_row);
        t_draw       draws[$];
        int unsigned x;
        int unsigned y;
        int unsigned stop;
        x = 32'(cursor_col);
        y = 32'(cursor_row);
        case (cmd)
            CMD_PUT: begin
                if (ch == CH_NEWLINE) begin
                    y = y + 1;
                    x = 0;
                end else if (ch == CH_BACKSPACE) begin
                    if (x > 0) begin
                        x = x - 1;
                    end else if (y > 0) begin
                        y = y - 1;
                        x = (int'(screen_cols) - 1) & 8'hFF;
                    end
                    draws.push_back(cell_draw(ACT_CLEAR, x, y, '0));
                end else if (ch == CH_DELETE) begin
                    draws.push_back(cell_draw(ACT_CLEAR, x, y, '0));
                end else if (ch == CH_TAB) begin
                    stop = (x + TAB_STEP) & TAB_MASK;
                    if (stop >= screen_cols) stop = 32'(screen_cols);
                    while (x < stop) begin
                        draws.push_back(cell_draw(ACT_CLEAR, x, y, '0));
                        x = x + 1;
                    end
                end else begin
                    draws.push_back(cell_draw(ACT_GLYPH, x, y, ch));
                    x = x + 1;
                end
                // wrap without 8-bit overflow, then scroll
                if (x >= screen_cols) begin
                    y = y + 1;
                    x = 0;
                end
                if (y >= screen_rows) begin
                    draws.push_back(cell_draw(ACT_SCROLL, 0, 0, '0));
                    y = (int'(screen_rows) - 1) & 8'hFF;
                end
                cursor_col = x[7:0];
                cursor_row = y[7:0];
            end
            CMD_SET: begin
                draws.push_back(cell_draw(ACT_CURSOR_OFF, 32'(cursor_col), 32'(cursor_row),
                                          '0));
                cursor_col = set_col;
                cursor_row = set_row;
                draws.push_back(cell_draw(ACT_CURSOR_ON, 32'(cursor_col), 32'(cursor_row),
                                          '0));
            end
            CMD_CLEAR: begin
                draws.push_back(cell_draw(ACT_FILL, 0, 0, '0));
                cursor_col = '0;
                cursor_row = '0;
            end
            default: ;
        endcase
        foreach (draws[k]) begin
            draws[k].last       = (k == draws.size() - 1);
            draws[k].cursor_col = cursor_col;
            draws[k].cursor_row = cursor_row;
            queued_draws.push_back(draws[k]);
        end
    endfunction

    function automatic void show_draw(string tag, t_draw d);
        $display("  %s: action=%0d cell=(%0d,%0d) glyph=%02h last=%0b cursor=(%0d,%0d)",
                 tag, d.action, d.cell_col, d.cell_row, d.glyph, d.last,
                 d.cursor_col, d.cursor_row);
    endfunction

    always @(posedge i_clk) begin : watch
        t_draw got;
        t_draw want;
        if (!i_rst_n) begin
            screen_cols = COLUMNS_RESET;
            screen_rows = TEXT_ROWS_RESET;
            cursor_col  = '0;
            cursor_row  = '0;
            queued_draws.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == CFG_COLUMNS) screen_cols = i_cfg.data;
                else if (i_cfg.index == CFG_TEXT_ROWS) screen_rows = i_cfg.data;
            end
            if (i_out.valid && i_out.ready) begin
                got.action     = i_out.action;
                got.cell_col   = i_out.cell_col;
                got.cell_row   = i_out.cell_row;
                got.glyph      = i_out.glyph;
                got.last       = i_out.last;
                got.cursor_col = i_out.cursor_col;
                got.cursor_row = i_out.cursor_row;
                if (queued_draws.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("%0t: drawing word with none expected", $time);
                        show_draw("actual", got);
                    end
                end else begin
                    want = queued_draws.pop_front();
                    if (got.action !== want.action || got.cell_col !== want.cell_col ||
                        got.cell_row !== want.cell_row || got.glyph !== want.glyph ||
                        got.last !== want.last || got.cursor_col !== want.cursor_col ||
                        got.cursor_row !== want.cursor_row) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("%0t: wrong drawing word", $time);
                            show_draw("expected", want);
                            show_draw("actual", got);
                        end
                    end
                end
            end
            if (i_in.valid && i_in.ready)
                plan_drawing(i_in.command, i_in.char_code, i_in.new_col, i_in.new_row);
        end
        o_mismatches    <= mismatches;
        o_draws_pending <= queued_draws.size();
    end

endmodule

FILE: sim/text_console_cursor_engine_tb.sv
// testbench top: stimulus, idling and verdict for the text console cursor engine
module text_console_cursor_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tcc_pkg::*;

    // longest stretch without any accepted word before the run is given up
    localparam int QUIET_LIMIT   = 3000;
    // idle cycles after the last drawing word before a register write
    localparam int SETTLE_CYCLES = 4;
    // idle cycles at the very end, to catch stray words
    localparam int DRAIN_CYCLES  = 16;
    // length of the long receiver hold-off
    localparam int HOLD_CYCLES   = 300;
    localparam int GROUP_ITEMS   = 50;

    logic i_clk;
    logic i_rst_n;

    tcc_in_if  in_ch ();
    tcc_out_if out_ch ();
    tcc_cfg_if cfg_ch ();

    int mismatches;
    int draws_pending;

    // idling chances in percent, and a request counter for the long hold-off
    int tx_idle_pct = 0;
    int rx_idle_pct;
    int hold_req;
    int quiet_cycles;

    // screen size as last written, used to shape the cursor positions
    logic [7:0] scr_cols;
    logic [7:0] scr_rows;

    text_console_cursor_engine dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    text_console_cursor_engine_checker checker_inst (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in            (in_ch),
        .i_out           (out_ch),
        .i_cfg           (cfg_ch),
        .o_mismatches    (mismatches),
        .o_draws_pending (draws_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // receiver side: random back-pressure, plus one long hold-off on request
    initial begin : sink_side
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // watchdog: any accepted word on any channel restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("text_console_cursor_engine: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // offer one command word and hold it until taken; valid stays high afterwards
    task automatic send_word(input logic [1:0] cmd, input logic [7:0] ch,
                             input logic [7:0] col, input logic [7:0] row);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.command   <= cmd;
        in_ch.char_code <= ch;
        in_ch.new_col   <= col;
        in_ch.new_row   <= row;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic put_char(input logic [7:0] ch);
        send_word(CMD_PUT, ch, 8'($urandom_range(255)), 8'($urandom_range(255)));
    endtask

    task automatic set_cursor(input logic [7:0] col, input logic [7:0] row);
        send_word(CMD_SET, 8'($urandom_range(255)), col, row);
    endtask

    // stop offering, let every expected word drain, then a short pause for
    // commands that leave no word behind
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (draws_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // register write; valid is left high so back-to-back writes keep one assignment per step
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
    endtask

    task automatic set_screen(input logic [7:0] cols, input logic [7:0] rows);
        settle();
        write_reg(CFG_COLUMNS, cols);
        write_reg(CFG_TEXT_ROWS, rows);
        cfg_ch.valid <= 1'b0;
        scr_cols = cols;
        scr_rows = rows;
    endtask

    // screen extent: mostly small so wrap and scroll come often, extremes now and then
    function automatic logic [7:0] pick_extent();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8) return 8'd0;
        if (pick < 16) return 8'd255;
        if (pick < 24) return 8'd1;
        if (pick < 64) return 8'($urandom_range(12, 2));
        return 8'($urandom_range(254, 13));
    endfunction

    function automatic logic [7:0] pick_on_screen(input logic [7:0] extent);
        if (extent == 0) return 8'($urandom_range(255));
        return 8'($urandom_range(int'(extent) - 1));
    endfunction

    // one random command word, weighted towards printing and cursor moves
    task automatic random_item();
        int pick;
        int sub;
        pick = $urandom_range(99);
        sub  = $urandom_range(9);
        if (pick < 72) begin
            case (sub)
                0:       put_char(CH_NEWLINE);
                1:       put_char(CH_BACKSPACE);
                2:       put_char(CH_DELETE);
                3, 4:    put_char(CH_TAB);
                default: put_char(8'($urandom_range(255)));
            endcase
        end else if (pick < 90) begin
            // mostly on screen, sometimes anywhere the fields allow
            if (sub < 8) set_cursor(pick_on_screen(scr_cols), pick_on_screen(scr_rows));
            else set_cursor(8'($urandom_range(255)), 8'($urandom_range(255)));
        end else if (pick < 96) begin
            send_word(CMD_CLEAR, 8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)));
        end else begin
            send_word(CMD_NONE, 8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)));
        end
    endtask

    // three screen sizes per phase; the long hold-off lands inside the first group
    task automatic run_phase(input int tx_pct, input int rx_pct, input bit with_hold);
        for (int grp = 0; grp < 3; grp++) begin
            set_screen(pick_extent(), pick_extent());
            if (grp == 0) begin
                tx_idle_pct = tx_pct;
                rx_idle_pct <= rx_pct;
                if (with_hold) hold_req <= hold_req + 1;
            end
            repeat (GROUP_ITEMS) random_item();
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        rx_idle_pct     <= 0;
        hold_req        <= 0;
        quiet_cycles    <= 0;
        in_ch.valid     <= 1'b0;
        in_ch.command   <= CMD_NONE;
        in_ch.char_code <= '0;
        in_ch.new_col   <= '0;
        in_ch.new_row   <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= CFG_COLUMNS;
        cfg_ch.data     <= '0;
        scr_cols = COLUMNS_RESET;
        scr_rows = TEXT_ROWS_RESET;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at the reset screen size
        put_char(8'h41);
        put_char(8'h00);
        put_char(8'hFF);
        put_char(CH_NEWLINE);                    // no drawing word at all
        put_char(CH_BACKSPACE);
        put_char(CH_DELETE);
        put_char(CH_TAB);
        send_word(CMD_NONE, 8'hFF, 8'hFF, 8'hFF); // unused command, ignored
        set_cursor(8'd79, 8'd24);
        put_char(8'h7E);                         // wrap at the last cell and scroll
        set_cursor(8'd255, 8'd255);              // cursor beyond the screen
        put_char(CH_TAB);                        // clears nothing, wraps and scrolls
        set_cursor(8'd0, 8'd0);
        put_char(CH_BACKSPACE);                  // stays at the origin
        set_cursor(8'd0, 8'd5);
        put_char(CH_BACKSPACE);                  // back to the end of the row above
        send_word(CMD_CLEAR, 8'h00, 8'hFF, 8'hFF);

        // tab near column 255 clamps instead of overflowing
        set_screen(8'd255, 8'd255);
        set_cursor(8'd250, 8'd254);
        put_char(CH_TAB);

        // zero columns and rows: every print wraps and scrolls
        set_screen(8'd0, 8'd0);
        put_char(8'h7A);
        put_char(CH_BACKSPACE);
        put_char(CH_TAB);

        // longest burst: eight clears plus a scroll
        set_screen(8'd8, 8'd1);
        set_cursor(8'd0, 8'd0);
        put_char(CH_TAB);
        put_char(CH_NEWLINE);                    // newline that scrolls

        // random part: receiver slow, then sender slow, then no idling with a hold-off
        run_phase(9, 75, 1'b0);
        run_phase(75, 9, 1'b0);
        run_phase(0, 0, 1'b1);

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("text_console_cursor_engine: match");
        end else begin
            $display("text_console_cursor_engine: mismatch");
        end
        $finish;
    end

endmodule
